// ===== rtl/csfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csfb_pkg: shared types and constants of the checked serial frame builder
// Holds the frame descriptor passed from the front end to the back end, the
// frame byte constants and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package csfb_pkg;

  localparam int unsigned StepW = 3;

  localparam logic [7:0] CrcInit  = 8'h79;
  localparam logic [7:0] CrcPoly  = 8'h8C;
  localparam logic [7:0] HdrLock  = 8'h02;
  localparam logic [7:0] HdrRadio = 8'hA1;
  localparam logic [7:0] Trailer  = 8'hFF;
  localparam logic [7:0] ZeroByte = 8'h00;

  localparam logic FmtLock  = 1'b0;
  localparam logic FmtRadio = 1'b1;

  localparam logic KindStart   = 1'b0;
  localparam logic KindPayload = 1'b1;

  localparam logic [StepW-1:0] StepFirst   = 3'd0;
  localparam logic [StepW-1:0] StepPayChk  = 3'd1;
  localparam logic [StepW-1:0] StepPayTrl  = 3'd2;
  localparam logic [StepW-1:0] StepHdrLast = 3'd3;
  localparam logic [StepW-1:0] StepHdrChk  = 3'd4;
  localparam logic [StepW-1:0] StepHdrTrl  = 3'd5;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_STRAY   = 2'd2
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       fmt;
    logic       close;
    logic [7:0] cmd;
    logic [7:0] data;
  } desc_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/csfb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csfb_front: input word classifier
// Tracks the open frame and the payload bytes still expected, holds the
// format register and turns each accepted word into one descriptor.
// ----------------------------------------------------------------------------
module csfb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire logic [23:0]   s_tdata_i,
  input  wire logic          s_tuser_i,
  input  wire logic          full_i,
  output logic               push_o,
  output csfb_pkg::desc_t    desc_o
);
  import csfb_pkg::*;

  logic       format_q, format_d;
  logic       open_q, open_d;
  logic       open_fmt_q, open_fmt_d;
  logic [7:0] left_q, left_d;
  logic [7:0] cmd;
  logic [7:0] len;
  logic [7:0] pbyte;
  logic [7:0] left_next;

  assign cmd   = s_tdata_i[7:0];
  assign len   = s_tdata_i[15:8];
  assign pbyte = s_tdata_i[23:16];

  assign s_tready_o = ~full_i;
  assign push_o     = s_tvalid_i & s_tready_o;

  always_comb begin
    format_d   = cfg_we_i ? cfg_wdata_i : format_q;
    open_d     = open_q;
    open_fmt_d = open_fmt_q;
    left_d     = left_q;
    left_next  = 8'd0;
    desc_o.op    = OP_STRAY;
    desc_o.fmt   = open_fmt_q;
    desc_o.close = 1'b0;
    desc_o.cmd   = cmd;
    desc_o.data  = pbyte;
    if (s_tuser_i == KindStart) begin
      left_next    = (len > 8'd1) ? (len - 8'd1) : 8'd0;
      desc_o.op    = OP_START;
      desc_o.fmt   = format_q;
      desc_o.data  = len;
      desc_o.close = (left_next == 8'd0);
      if (push_o) begin
        open_fmt_d = format_q;
        open_d     = (left_next != 8'd0);
        left_d     = left_next;
      end
    end else if (open_q) begin
      left_next    = (left_q > 8'd0) ? (left_q - 8'd1) : left_q;
      desc_o.op    = OP_PAYLOAD;
      desc_o.close = (left_next == 8'd0);
      if (push_o) begin
        open_d = (left_next != 8'd0);
        left_d = left_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q   <= FmtLock;
      open_q     <= 1'b0;
      open_fmt_q <= FmtLock;
      left_q     <= 8'd0;
    end else begin
      format_q   <= format_d;
      open_q     <= open_d;
      open_fmt_q <= open_fmt_d;
      left_q     <= left_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/csfb_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csfb_fifo: descriptor queue
// A short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module csfb_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire csfb_pkg::desc_t  wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output csfb_pkg::desc_t       rdata_o
);
  import csfb_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  desc_t         mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/csfb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csfb_back: frame byte sequencer
// Expands each descriptor into its frame bytes, one per cycle when output is
// ready, keeps the running CRC-8 or sum and drives the registered output word.
// ----------------------------------------------------------------------------
module csfb_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire csfb_pkg::desc_t  desc_i,
  output logic                  pop_o,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic [7:0]            m_tdata_o,
  output logic                  m_tlast_o,
  output logic [1:0]            m_tuser_o
);
  import csfb_pkg::*;

  desc_t            cur_q, cur_d;
  logic             cur_valid_q, cur_valid_d;
  logic [StepW-1:0] step_q, step_d;
  logic [7:0]       chk_q, chk_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;
  logic             odone_q, odone_d;
  logic             ostray_q, ostray_d;

  logic             lock;
  logic             emit;
  logic [7:0]       byte_c;
  logic             is_data;
  logic             last_c;
  logic             done_c;
  logic             stray_c;
  logic [7:0]       base;

  assign lock = (cur_q.fmt == FmtLock);
  assign emit = cur_valid_q & (~ovalid_q | m_tready_i);

  always_comb begin
    byte_c  = ZeroByte;
    is_data = 1'b0;
    last_c  = 1'b0;
    stray_c = 1'b0;
    case (cur_q.op)
      OP_START: begin
        case (step_q)
          StepFirst:   byte_c = lock ? HdrLock : HdrRadio;
          StepPayChk:  byte_c = lock ? cur_q.data : cur_q.cmd;
          StepPayTrl:  byte_c = ZeroByte;
          StepHdrLast: byte_c = lock ? cur_q.cmd : cur_q.data;
          StepHdrChk:  byte_c = chk_q;
          default:     byte_c = Trailer;
        endcase
        is_data = (step_q < StepHdrChk);
        last_c  = cur_q.close ? (step_q == (lock ? StepHdrTrl : StepHdrChk))
                              : (step_q == StepHdrLast);
      end
      OP_PAYLOAD: begin
        case (step_q)
          StepFirst:  byte_c = cur_q.data;
          StepPayChk: byte_c = chk_q;
          default:    byte_c = Trailer;
        endcase
        is_data = (step_q == StepFirst);
        last_c  = cur_q.close ? (step_q == (lock ? StepPayTrl : StepPayChk))
                              : (step_q == StepFirst);
      end
      default: begin
        byte_c  = ZeroByte;
        last_c  = 1'b1;
        stray_c = 1'b1;
      end
    endcase
    done_c = last_c & cur_q.close & ~stray_c;
  end

  always_comb begin
    base = chk_q;
    if ((cur_q.op == OP_START) && (step_q == StepFirst)) begin
      base = lock ? CrcInit : ZeroByte;
    end
    chk_d = chk_q;
    if (emit && is_data) begin
      chk_d = lock ? crc8_update(base, byte_c) : (base + byte_c);
    end
  end

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    step_d      = step_q;
    pop_o       = 1'b0;
    ovalid_d    = ovalid_q & ~m_tready_i;
    obyte_d     = obyte_q;
    olast_d     = olast_q;
    odone_d     = odone_q;
    ostray_d    = ostray_q;
    if (emit) begin
      ovalid_d = 1'b1;
      obyte_d  = byte_c;
      olast_d  = last_c;
      odone_d  = done_c;
      ostray_d = stray_c;
      if (last_c) begin
        pop_o       = valid_i;
        cur_valid_d = valid_i;
        cur_d       = desc_i;
        step_d      = StepFirst;
      end else begin
        step_d = step_q + StepW'(1);
      end
    end else if (!cur_valid_q) begin
      pop_o       = valid_i;
      cur_valid_d = valid_i;
      cur_d       = desc_i;
      step_d      = StepFirst;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    obyte_q  <= obyte_d;
    olast_q  <= olast_d;
    odone_q  <= odone_d;
    ostray_q <= ostray_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= StepFirst;
      chk_q       <= ZeroByte;
      ovalid_q    <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      step_q      <= step_d;
      chk_q       <= chk_d;
      ovalid_q    <= ovalid_d;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = obyte_q;
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = {ostray_q, odone_q};

endmodule
`default_nettype wire

// ===== rtl/checked_serial_frame_builder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checked_serial_frame_builder: serial frame builder with CRC-8 or sum check
// Input words are start items (command and length) or payload bytes. Each
// word yields one or more output words, one frame byte each. A start word
// gives the header, four bytes, plus the check (and the 0xFF trailer in the
// lock format) when the frame has no payload. A payload word gives its byte,
// plus the check (and the trailer in the lock format) when it is the last one.
// A payload word with no open frame gives a single word flagged as a stray
// error. The format register is sampled at each start word. An input word's
// first output word passes the queue, the sequencer's register and the output
// register. Output runs at one word per cycle while the receiver is ready;
// the input takes one word per cycle while the queue has room, so sustained
// input rate is set by the number of output words each input word causes
// (one to six). Reset clears the open frame, the queue and the output
// register, and sets the format to lock. When the receiver stalls, the output
// word holds, the sequencer waits, and the queue fills until s_tready_o falls.
// ----------------------------------------------------------------------------
module checked_serial_frame_builder #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,  // frame_format
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [23:0] s_tdata_i,    // command, frame_len, payload_byte
  input  wire logic        s_tuser_i,    // kind
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [7:0]       m_tdata_o,    // out_byte
  output logic             m_tlast_o,    // end_of_run
  output logic [1:0]       m_tuser_o     // frame_done, stray_error
);
  import csfb_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  q_valid;
  desc_t wr_desc;
  desc_t rd_desc;

  csfb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .full_i     (full),
    .push_o     (push),
    .desc_o     (wr_desc)
  );

  csfb_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(wr_desc),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rdata_o(rd_desc)
  );

  csfb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .desc_i    (rd_desc),
    .pop_o     (pop),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tlast_o (m_tlast_o),
    .m_tuser_o (m_tuser_o)
  );

endmodule
`default_nettype wire
